### design/abic_pkg.sv
// ----------------------------------------------------------------------------
// abic_pkg
// Shared types and constants of the ADC block average, IIR and current core.
// ----------------------------------------------------------------------------
package abic_pkg;

  localparam int SAMPLES_PER_BLOCK = 16;
  localparam int SAMPLE_BITS       = 12;

  localparam int SAMPLE_W  = 12;
  localparam int ALPHA_W   = 16;
  localparam int GAIN_W    = 32;
  localparam int Q128_W    = 20;
  localparam int CURRENT_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam int SUM_W = $clog2(SAMPLES_PER_BLOCK * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int CNT_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
  localparam int AVG_FULL_W = SUM_W + 8;

  // shared multiplier: signed difference times signed coefficient
  localparam int DIFF_W = Q128_W + 1;
  localparam int COEF_W = GAIN_W + 1;
  localparam int PROD_W = DIFF_W + COEF_W;

  localparam logic [SAMPLE_W-1:0]  SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [Q128_W-1:0]    Q128_MAX    = '1;
  localparam logic [ALPHA_W-1:0]   ALPHA_RESET = 16'd6554;
  localparam logic [GAIN_W-1:0]    GAIN_RESET  = 32'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'd1;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CAL    = 1'b1;

  typedef enum logic {
    OP_SMOOTH  = 1'b0,   // (avg - filtered) * alpha
    OP_CURRENT = 1'b1    // (filtered - zero) * gain
  } alu_op_t;

  typedef struct packed {
    logic    en;
    alu_op_t op;
  } alu_ctl_t;

endpackage

### design/abic_if.sv
// ----------------------------------------------------------------------------
// abic_in_if / abic_out_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface abic_in_if;
  import abic_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, mode, sample, input ready);
  modport sink   (input valid, mode, sample, output ready);
endinterface

interface abic_out_if;
  import abic_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [Q128_W-1:0]           filtered_value;
  logic signed [CURRENT_W-1:0] current_value;

  modport source (output valid, filtered_value, current_value, input ready);
  modport sink   (input valid, filtered_value, current_value, output ready);
endinterface

### design/abic_alu.sv
// ----------------------------------------------------------------------------
// abic_alu
// Shared subtract-and-multiply unit with a registered product.
// ----------------------------------------------------------------------------
module abic_alu (
  input  logic                               clk,
  input  abic_pkg::alu_ctl_t                 ctl,
  input  logic [abic_pkg::Q128_W-1:0]        avg,
  input  logic [abic_pkg::Q128_W-1:0]        filt,
  input  logic [abic_pkg::Q128_W-1:0]        zero,
  input  logic [abic_pkg::ALPHA_W-1:0]       alpha,
  input  logic [abic_pkg::GAIN_W-1:0]        gain,
  output logic signed [abic_pkg::PROD_W-1:0] prod_r
);
  import abic_pkg::*;

  logic [Q128_W-1:0]        op_a;
  logic [Q128_W-1:0]        op_b;
  logic signed [DIFF_W-1:0] diff;
  logic signed [COEF_W-1:0] coef;

  always_comb begin
    case (ctl.op)
      OP_SMOOTH: begin
        op_a = avg;
        op_b = filt;
        coef = COEF_W'({1'b0, alpha});
      end
      default: begin
        op_a = filt;
        op_b = zero;
        coef = {gain[GAIN_W-1], gain};
      end
    endcase
    diff = $signed({1'b0, op_a}) - $signed({1'b0, op_b});
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= diff * coef;
    end
  end

endmodule

### design/adc_block_average_iir_current_core.sv
// ----------------------------------------------------------------------------
// adc_block_average_iir_current_core
// Block averaging of ADC samples, first-order IIR smoothing, scaled current.
// ----------------------------------------------------------------------------
// in_if carries one item per handshake: mode 0 adds a 12-bit sample to the
// running block, mode 1 copies the filtered value into the zero offset.
// in_if.ready stays high for sample items unless one closes a block of
// SAMPLES_PER_BLOCK samples; then the sequencer runs the shared multiplier
// twice (smoothing step, then current scaling) and in_if.ready stays low
// through multiply, filter update, multiply and load of the output register.
// The result (filtered Q12.8 value, saturated Q16.16 current) appears on
// out_if in the cycle after that load step, which waits while the output
// register is still occupied.
// Calibrate items and non-closing samples give no result.
// The result is held in an output register; sample items keep flowing while
// it waits. If the receiver still stalls when the next block closes, the
// sequencer holds in its final step until the register frees.
// cfg_we writes smoothing_alpha (index 0) or current_gain (index 1) at once.
// rst_n (synchronous, active low) clears the block sum, count, filter state
// and zero offset and restores the register defaults.
// ----------------------------------------------------------------------------
module adc_block_average_iir_current_core (
  input  logic                                clk,
  input  logic                                rst_n,
  abic_in_if.sink                             in_if,
  abic_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [abic_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [abic_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import abic_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL1 = 5'b00010,
    S_UPD  = 5'b00100,
    S_MUL2 = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [Q128_W-1:0]        filt_r, filt_nxt;
  logic [Q128_W-1:0]        zero_r, zero_nxt;
  logic [ALPHA_W-1:0]       alpha_r;
  logic [GAIN_W-1:0]        gain_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [Q128_W-1:0]        out_filt_r;
  logic signed [CURRENT_W-1:0] out_cur_r;

  logic                     in_fire;
  logic [SAMPLE_W-1:0]      smp;
  logic [AVG_FULL_W-1:0]    avg_full;
  logic [Q128_W-1:0]        avg;
  alu_ctl_t                 alu_ctl;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] step;
  logic signed [PROD_W-1:0] cur_wide;
  logic signed [CURRENT_W-1:0] cur_sat;
  logic                     out_free;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign smp         = in_if.sample & SAMPLE_MASK;

  assign avg_full = AVG_FULL_W'({sum_r, 8'd0} / SAMPLES_PER_BLOCK);
  assign avg      = (avg_full > AVG_FULL_W'(Q128_MAX)) ? Q128_MAX : avg_full[Q128_W-1:0];

  assign step     = prod_r >>> 16;
  assign cur_wide = prod_r >>> 8;

  always_comb begin
    if (cur_wide > PROD_W'(32'sh7FFFFFFF)) begin
      cur_sat = 32'sh7FFFFFFF;
    end else if (cur_wide < -PROD_W'(64'sh80000000)) begin
      cur_sat = 32'sh80000000;
    end else begin
      cur_sat = cur_wide[CURRENT_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_if.ready;

  abic_alu u_alu (
    .clk    (clk),
    .ctl    (alu_ctl),
    .avg    (avg),
    .filt   (filt_r),
    .zero   (zero_r),
    .alpha  (alpha_r),
    .gain   (gain_r),
    .prod_r (prod_r)
  );

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    filt_nxt      = filt_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    alu_ctl.en    = 1'b0;
    alu_ctl.op    = OP_SMOOTH;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_if.mode == MODE_CAL) begin
            zero_nxt = filt_r;
          end else begin
            sum_nxt = sum_r + SUM_W'(smp);
            if (cnt_r == CNT_W'(SAMPLES_PER_BLOCK - 1)) begin
              state_nxt = S_MUL1;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end
      S_MUL1: begin
        alu_ctl.en = 1'b1;
        alu_ctl.op = OP_SMOOTH;
        sum_nxt    = '0;
        cnt_nxt    = '0;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        filt_nxt  = filt_r + step[Q128_W-1:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        alu_ctl.en = 1'b1;
        alu_ctl.op = OP_CURRENT;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register frees
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      filt_r      <= '0;
      zero_r      <= '0;
      out_valid_r <= 1'b0;
      alpha_r     <= ALPHA_RESET;
      gain_r      <= GAIN_RESET;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      filt_r      <= filt_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ALPHA: alpha_r <= cfg_wdata[ALPHA_W-1:0];
          REG_GAIN:  gain_r  <= cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_filt_r <= filt_r;
      out_cur_r  <= cur_sat;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.filtered_value = out_filt_r;
  assign out_if.current_value  = out_cur_r;

endmodule

### design/abic_checker.sv
// ----------------------------------------------------------------------------
// abic_checker
// Port-level checks of the core, attached by bind.
// ----------------------------------------------------------------------------
module abic_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_mode,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [abic_pkg::CURRENT_W-1:0] out_current
);
  import abic_pkg::*;

  // a result waits in its register until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_current))
    else $error("result item dropped or changed while stalled");

  // nothing is pending right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // a new result follows a busy cycle of the sequencer
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result item without a block end");

  // a calibrate item never produces a result
  a_cal_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_CAL |=> !$rose(out_valid))
    else $error("calibrate item produced a result");

endmodule

bind adc_block_average_iir_current_core abic_checker u_abic_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .in_mode     (in_if.mode),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_current (out_if.current_value)
);
